@@ hdl/sli_pkg.sv @@
// Shared types and codes for the sorted list intersection core.
// Used by sorted_list_intersection_core; no dependencies.
`default_nettype none

package sli_pkg;

    localparam logic [1:0] OP_APPEND_A = 2'd0;
    localparam logic [1:0] OP_APPEND_B = 2'd1;
    localparam logic [1:0] OP_RUN      = 2'd2;

    localparam int unsigned VALUE_W = 32;

    typedef struct packed {
        logic [1:0]                op;
        logic signed [VALUE_W-1:0] value;
    } t_in_req;

    typedef struct packed {
        logic signed [VALUE_W-1:0] common_value;
        logic                      found;
        logic                      last;
    } t_out_res;

endpackage

`default_nettype wire

@@ hdl/sli_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module sli_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic                                    i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/sorted_list_intersection_core.sv @@
// Sorted list intersection core: two-pointer merge over two list memories.
// Append request: accepted with no result. Run request: each merge step is a memory
// read, then a compare; at most count_a + count_b - 1 steps, then one end check and
// the queuing of the final result, plus any output stall; each match
// is held until the next match or the run end shows whether it is last.
// One request at a time; the next is taken once the run has queued its last result.
// Reset (synchronous, i_rst_n low) clears counts and control; list memories keep
// undefined contents and get no clearing pass.
`default_nettype none

module sorted_list_intersection_core #(
    parameter int unsigned DEPTH = 64
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire sli_pkg::t_in_req  i_in_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output sli_pkg::t_out_res    o_out_data
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CHK  = 4'b0010,
        S_CMP  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state                          r_state, n_state;
    logic [CW-1:0]                   r_count_a, n_count_a;
    logic [CW-1:0]                   r_count_b, n_count_b;
    logic [CW-1:0]                   r_ia, n_ia;
    logic [CW-1:0]                   r_ib, n_ib;
    logic                            r_pend_valid, n_pend_valid;
    logic signed [sli_pkg::VALUE_W-1:0] r_pend_value, n_pend_value;
    logic                            r_out_valid, n_out_valid;
    sli_pkg::t_out_res               r_out_data, n_out_data;

    logic                            w_accept;
    logic                            w_out_free;
    logic                            w_more;
    logic                            w_we_a, w_we_b, w_re;
    logic [sli_pkg::VALUE_W-1:0]     w_rd_a, w_rd_b;

    // Writes happen only while idle and reads only during a run, so the two
    // ports never touch the same entry in one cycle.
    sli_ram #(.WIDTH(sli_pkg::VALUE_W), .DEPTH(DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (r_count_a[AW-1:0]),
        .i_wdata (i_in_data.value),
        .i_re    (w_re),
        .i_raddr (r_ia[AW-1:0]),
        .o_rdata (w_rd_a)
    );

    sli_ram #(.WIDTH(sli_pkg::VALUE_W), .DEPTH(DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (r_count_b[AW-1:0]),
        .i_wdata (i_in_data.value),
        .i_re    (w_re),
        .i_raddr (r_ib[AW-1:0]),
        .o_rdata (w_rd_b)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_more     = (r_ia < r_count_a) && (r_ib < r_count_b);

    always_comb begin
        n_state      = r_state;
        n_count_a    = r_count_a;
        n_count_b    = r_count_b;
        n_ia         = r_ia;
        n_ib         = r_ib;
        n_pend_valid = r_pend_valid;
        n_pend_value = r_pend_value;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_data   = r_out_data;
        w_we_a       = 1'b0;
        w_we_b       = 1'b0;
        w_re         = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_in_data.op)
                        sli_pkg::OP_APPEND_A: begin
                            if (r_count_a != FULL) begin
                                w_we_a    = 1'b1;
                                n_count_a = r_count_a + 1'b1;
                            end
                        end
                        sli_pkg::OP_APPEND_B: begin
                            if (r_count_b != FULL) begin
                                w_we_b    = 1'b1;
                                n_count_b = r_count_b + 1'b1;
                            end
                        end
                        sli_pkg::OP_RUN: begin
                            n_ia         = '0;
                            n_ib         = '0;
                            n_pend_valid = 1'b0;
                            n_state      = S_CHK;
                        end
                        default: begin
                            // unused code: drop
                        end
                    endcase
                end
            end
            S_CHK: begin
                if (w_more) begin
                    w_re    = 1'b1;
                    n_state = S_CMP;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_CMP: begin
                if ($signed(w_rd_a) == $signed(w_rd_b)) begin
                    // Hold the match until the next one shows whether it is last.
                    if (!r_pend_valid || w_out_free) begin
                        if (r_pend_valid) begin
                            n_out_valid             = 1'b1;
                            n_out_data.common_value = r_pend_value;
                            n_out_data.found        = 1'b1;
                            n_out_data.last         = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_value = $signed(w_rd_a);
                        n_ia         = r_ia + 1'b1;
                        n_ib         = r_ib + 1'b1;
                        n_state      = S_CHK;
                    end
                end else if ($signed(w_rd_a) > $signed(w_rd_b)) begin
                    n_ib    = r_ib + 1'b1;
                    n_state = S_CHK;
                end else begin
                    n_ia    = r_ia + 1'b1;
                    n_state = S_CHK;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_out_valid             = 1'b1;
                    n_out_data.common_value = r_pend_valid ? r_pend_value : '0;
                    n_out_data.found        = r_pend_valid;
                    n_out_data.last         = 1'b1;
                    n_count_a               = '0;
                    n_count_b               = '0;
                    n_state                 = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count_a    <= '0;
            r_count_b    <= '0;
            r_ia         <= '0;
            r_ib         <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count_a    <= n_count_a;
            r_count_b    <= n_count_b;
            r_ia         <= n_ia;
            r_ib         <= n_ib;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_value <= n_pend_value;
        r_out_data   <= n_out_data;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count_a <= FULL) && (r_count_b <= FULL))
        else $error("list count exceeds capacity");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> ((r_ia < r_count_a) && (r_ib < r_count_b)))
        else $error("merge pointer read beyond list");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.found) |->
            (o_out_data.last && (o_out_data.common_value == '0)))
        else $error("empty result not marked last with zero value");

    a_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && w_out_free) |=>
            ((r_count_a == '0) && (r_count_b == '0) && o_out_valid && o_out_data.last))
        else $error("run end did not clear lists or queue last result");

    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in_data.op == sli_pkg::OP_RUN)) |=>
            ((r_state == S_CHK) && (r_ia == '0) && (r_ib == '0) && !r_pend_valid))
        else $error("run did not start from list heads");

endmodule

`default_nettype wire
